FILE: sv/bitmap_block_allocator_top_defines.svh
// ---------------------------------------------------------------------------
// Bitmap block allocator assertion macros
// Shared concurrent assertion forms for the allocator RTL.
// ---------------------------------------------------------------------------
`ifndef BITMAP_BLOCK_ALLOCATOR_TOP_DEFINES_SVH
`define BITMAP_BLOCK_ALLOCATOR_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BBA_ASSERT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define BBA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/bba_pkg.sv
// ---------------------------------------------------------------------------
// Bitmap block allocator package
// Block state codes, word geometry, operation codes and shared types.
// ---------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

   // Block state codes
   localparam logic [1:0] ST_FREE  = 2'b00;
   localparam logic [1:0] ST_USED  = 2'b01;
   localparam logic [1:0] ST_FIRST = 2'b10;

   // Operation codes
   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   // Blocks packed into one state memory word
   localparam int LANES  = 16;
   localparam int LANE_W = 4;
   localparam int WORD_W = 2 * LANES;

   // Field widths
   localparam int SIZE_W    = 15;
   localparam int SIZE_DV_W = SIZE_W + 1;
   localparam int NEED_W    = SIZE_W;
   localparam int ADDR_W    = 64;

   // Defaults for the top level parameters
   localparam int DEF_NUM_BLOCKS  = 4096;
   localparam int DEF_BLOCK_BYTES = 4;

   typedef logic [1:0] state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

`default_nettype wire

FILE: sv/bba_divider.sv
// ---------------------------------------------------------------------------
// Bitmap block allocator divider
// Division by the constant block size through a reciprocal multiply; the started
// dividend is registered, then multiplied, and the quotient is registered with done.
// ---------------------------------------------------------------------------
`default_nettype none

module bba_divider #(
   parameter int DV_W    = 16,
   parameter int DIVISOR = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DV_W-1:0]       dividend,
   output bba_pkg::div_stat_type stat,
   output logic [DV_W-1:0]       quotient
);
   import bba_pkg::*;

   // floor(x / d) equals (x * RECIP) >> (DV_W + SH) for every x below 2^DV_W
   localparam int SH  = $clog2(DIVISOR);
   localparam int M_W = DV_W + 1;
   localparam int P_W = DV_W + M_W;
   localparam longint unsigned RECIP =
      ((64'd1 << (DV_W + SH)) / 64'(DIVISOR)) + 64'd1;

   logic [DV_W-1:0] x_ff,    x_in;
   logic [DV_W-1:0] q_ff,    q_in;
   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [P_W-1:0]  prod;

   assign prod = P_W'(x_ff) * P_W'(M_W'(RECIP));

   always_comb begin
      x_in    = x_ff;
      q_in    = q_ff;
      busy_in = 1'b0;
      done_in = 1'b0;
      if (start) begin
         x_in    = dividend;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // multiply the held dividend; the quotient is registered with done
         q_in    = DV_W'(prod >> (DV_W + SH));
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      x_ff <= x_in;
      q_ff <= q_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = q_ff;

endmodule

`default_nettype wire

FILE: sv/bitmap_block_allocator_top.sv
// ---------------------------------------------------------------------------
// Bitmap block allocator
// First-fit heap allocator over fixed-size blocks, two state bits a block,
// kept in one packed state memory swept word by word.
// ---------------------------------------------------------------------------
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  req_func, req_size_bytes, req_address
//   rsp      out        rsp_valid / rsp_stall  rsp_result_address, rsp_success
//   csr      in         csr_write_enable       csr_write_data (base address)
//
// One item at a time: offset and launch come first, then the block-size divide (a free
// outside the heap skips it). An allocate scans one 16-block word a cycle, up to the
// last of WORDS words (256 at defaults), then rewrites the run's words one a cycle; a
// free rewrites one word a cycle up to the next first block or the last word; then the
// result is loaded once the output register is free. After reset a clearing pass writes
// every word to free with req_stall high; csr writes are taken at any time. A stalled
// result holds in the output register while the next item is accepted.
// ---------------------------------------------------------------------------
`default_nettype none

`include "bitmap_block_allocator_top_defines.svh"

module bitmap_block_allocator_top #(
   parameter int NUM_BLOCKS  = bba_pkg::DEF_NUM_BLOCKS,
   parameter int BLOCK_BYTES = bba_pkg::DEF_BLOCK_BYTES
) (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_func,
   input  logic [bba_pkg::SIZE_W-1:0]  req_size_bytes,
   input  logic [bba_pkg::ADDR_W-1:0]  req_address,
   // response channel
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [bba_pkg::ADDR_W-1:0]  rsp_result_address,
   output logic                        rsp_success,
   // configuration
   input  logic                        csr_write_enable,
   input  logic [bba_pkg::ADDR_W-1:0]  csr_write_data
);
   import bba_pkg::*;

   // Geometry
   localparam int WORDS = (NUM_BLOCKS + LANES - 1) / LANES;
   localparam int WA_W  = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int GB_W  = WA_W + LANE_W;
   localparam longint unsigned HEAP_BYTES = 64'(NUM_BLOCKS) * 64'(BLOCK_BYTES);
   localparam int OFF_W  = (HEAP_BYTES > 2) ? $clog2(HEAP_BYTES) : 1;
   localparam int DV_W   = (OFF_W > SIZE_DV_W) ? OFF_W : SIZE_DV_W;
   localparam int QX_W   = (DV_W > GB_W) ? DV_W : GB_W;
   localparam int RUN_W  = NEED_W + 1;
   localparam int SW     = ((GB_W > NEED_W) ? GB_W : NEED_W) + 1;
   localparam int PROD_W = GB_W + $clog2(BLOCK_BYTES + 1);
   localparam logic [WA_W-1:0] LAST_WORD = WA_W'(WORDS - 1);

   // Sequencer states
   localparam logic [3:0] S_CLEAR  = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_PREP   = 4'd2;
   localparam logic [3:0] S_LAUNCH = 4'd3;
   localparam logic [3:0] S_DIV    = 4'd4;
   localparam logic [3:0] S_SCAN   = 4'd5;
   localparam logic [3:0] S_MARK   = 4'd6;
   localparam logic [3:0] S_FREE   = 4'd7;
   localparam logic [3:0] S_RESP   = 4'd8;

   // -----------------------------------------------------------------------
   // Registers
   // -----------------------------------------------------------------------
   logic [3:0]          state_ff,     state_in;
   logic [WA_W-1:0]     cur_word_ff,  cur_word_in;
   logic                func_ff,      func_in;
   logic [SIZE_W-1:0]   size_ff,      size_in;
   logic [ADDR_W-1:0]   address_ff,   address_in;
   logic [ADDR_W-1:0]   offset_ff,    offset_in;
   logic                range_ok_ff,  range_ok_in;
   logic [NEED_W-1:0]   need_ff,      need_in;
   logic [NEED_W-1:0]   carry_ff,     carry_in;
   logic [GB_W-1:0]     idx_blk_ff,   idx_blk_in;
   logic [GB_W-1:0]     start_blk_ff, start_blk_in;
   logic [GB_W-1:0]     end_blk_ff,   end_blk_in;
   logic                ok_ff,        ok_in;
   logic [PROD_W-1:0]   prod_ff,      prod_in;
   logic [ADDR_W-1:0]   base_ff,      base_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]   rsp_addr_ff,  rsp_addr_in;
   logic                rsp_ok_ff,    rsp_ok_in;

   // -----------------------------------------------------------------------
   // State memory: one write port, one registered read port
   // -----------------------------------------------------------------------
   logic [WORD_W-1:0] mem [WORDS];
   logic [WORD_W-1:0] rd_data_ff;
   logic              rd_en, wr_en;
   logic [WA_W-1:0]   rd_addr, wr_addr;
   logic [WORD_W-1:0] wr_data;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // -----------------------------------------------------------------------
   // Divider for block index and block count
   // -----------------------------------------------------------------------
   logic            div_start;
   logic [DV_W-1:0] div_dividend;
   logic [DV_W-1:0] div_q;
   logic [QX_W-1:0] div_qx;
   div_stat_type    div_stat;

   // free divides the heap offset, allocate divides size rounded up
   assign div_dividend = (func_ff == FUNC_FREE) ? DV_W'(offset_ff[OFF_W-1:0])
                       : DV_W'(SIZE_DV_W'(size_ff) + SIZE_DV_W'(BLOCK_BYTES - 1));
   assign div_qx       = QX_W'(div_q);

   bba_divider #(
      .DV_W    (DV_W),
      .DIVISOR (BLOCK_BYTES)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .stat     (div_stat),
      .quotient (div_q)
   );

   // -----------------------------------------------------------------------
   // First-fit lane logic on the word just read
   // -----------------------------------------------------------------------
   logic [LANES-1:0]  lane_free;
   logic [RUN_W-1:0]  run_v [LANES];
   logic              seen_nf;
   logic [LANE_W-1:0] last_nf;
   logic              hit;
   logic [LANE_W-1:0] hit_lane;
   logic [NEED_W-1:0] carry_next;
   logic [GB_W-1:0]   hit_blk;
   logic [SW-1:0]     start_sw;

   always_comb begin
      seen_nf  = 1'b0;
      last_nf  = '0;
      hit      = 1'b0;
      hit_lane = '0;
      for (int j = 0; j < LANES; j++) begin
         // lanes past the heap end never count as free
         lane_free[j] = ({1'b0, cur_word_ff, LANE_W'(j)} < (GB_W+1)'(NUM_BLOCKS))
                        && (rd_data_ff[2*j +: 2] == ST_FREE);
      end
      for (int j = 0; j < LANES; j++) begin
         seen_nf = 1'b0;
         last_nf = '0;
         for (int k = 0; k < LANES; k++) begin
            if (k <= j && !lane_free[k]) begin
               seen_nf = 1'b1;
               last_nf = LANE_W'(k);
            end
         end
         if (!lane_free[j]) begin
            run_v[j] = '0;
         end else if (seen_nf) begin
            run_v[j] = RUN_W'(j) - RUN_W'(last_nf);
         end else begin
            // run continues from earlier words
            run_v[j] = RUN_W'(carry_ff) + RUN_W'(j + 1);
         end
      end
      for (int j = LANES - 1; j >= 0; j--) begin
         if (lane_free[j] && run_v[j] >= RUN_W'(need_ff)) begin
            hit      = 1'b1;
            hit_lane = LANE_W'(j);
         end
      end
      if (&lane_free) begin
         carry_next = carry_ff + NEED_W'(LANES);
      end else begin
         carry_next = run_v[LANES-1][NEED_W-1:0];
      end
   end

   assign hit_blk  = {cur_word_ff, hit_lane};
   assign start_sw = SW'(hit_blk) - SW'(need_ff) + SW'(1);

   // -----------------------------------------------------------------------
   // Marking: first block gets FIRST, the rest of the run USED
   // -----------------------------------------------------------------------
   logic [WA_W-1:0]   start_word, end_word;
   logic [LANE_W-1:0] mark_lo, mark_hi;
   logic              at_start;
   logic [WORD_W-1:0] mark_wdata;

   assign start_word = start_blk_ff[GB_W-1:LANE_W];
   assign end_word   = end_blk_ff[GB_W-1:LANE_W];
   assign at_start   = (cur_word_ff == start_word);
   assign mark_lo    = at_start ? start_blk_ff[LANE_W-1:0] : '0;
   assign mark_hi    = (cur_word_ff == end_word) ? end_blk_ff[LANE_W-1:0]
                                                 : LANE_W'(LANES - 1);

   always_comb begin
      mark_wdata = rd_data_ff;
      for (int j = 0; j < LANES; j++) begin
         if (at_start && LANE_W'(j) == mark_lo) begin
            mark_wdata[2*j +: 2] = ST_FIRST;
         end else if (LANE_W'(j) >= mark_lo && LANE_W'(j) <= mark_hi) begin
            mark_wdata[2*j +: 2] = ST_USED;
         end
      end
   end

   // -----------------------------------------------------------------------
   // Freeing: clear up to, not including, the next FIRST block
   // -----------------------------------------------------------------------
   logic              free_first_w;
   logic [LANE_W-1:0] free_lo;
   logic              stop_seen;
   logic [WORD_W-1:0] free_wdata;
   logic              free_last;

   assign free_first_w = (cur_word_ff == idx_blk_ff[GB_W-1:LANE_W]);
   assign free_lo      = free_first_w ? idx_blk_ff[LANE_W-1:0] : '0;

   always_comb begin
      stop_seen  = 1'b0;
      free_wdata = rd_data_ff;
      for (int j = 0; j < LANES; j++) begin
         // the freed block itself never stops the sweep
         if (LANE_W'(j) >= free_lo && !(free_first_w && LANE_W'(j) == free_lo)
             && rd_data_ff[2*j +: 2] == ST_FIRST) begin
            stop_seen = 1'b1;
         end
         if (LANE_W'(j) >= free_lo && !stop_seen) begin
            free_wdata[2*j +: 2] = ST_FREE;
         end
      end
   end

   assign free_last = stop_seen || (cur_word_ff == LAST_WORD);

   // -----------------------------------------------------------------------
   // Sequencer
   // -----------------------------------------------------------------------
   logic rsp_load;

   always_comb begin
      state_in     = state_ff;
      cur_word_in  = cur_word_ff;
      func_in      = func_ff;
      size_in      = size_ff;
      address_in   = address_ff;
      offset_in    = offset_ff;
      range_ok_in  = range_ok_ff;
      need_in      = need_ff;
      carry_in     = carry_ff;
      idx_blk_in   = idx_blk_ff;
      start_blk_in = start_blk_ff;
      end_blk_in   = end_blk_ff;
      ok_in        = ok_ff;
      prod_in      = PROD_W'(start_blk_ff) * PROD_W'(BLOCK_BYTES);
      base_in      = csr_write_enable ? csr_write_data : base_ff;
      div_start    = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = cur_word_ff;
      wr_en        = 1'b0;
      wr_addr      = cur_word_ff;
      wr_data      = '0;
      rsp_load     = 1'b0;

      case (state_ff)
         S_CLEAR: begin
            wr_en = 1'b1;
            if (cur_word_ff == LAST_WORD) begin
               state_in = S_IDLE;
            end else begin
               cur_word_in = cur_word_ff + WA_W'(1);
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               func_in    = req_func;
               size_in    = req_size_bytes;
               address_in = req_address;
               state_in   = S_PREP;
            end
         end
         S_PREP: begin
            offset_in   = address_ff - base_ff;
            range_ok_in = (address_ff >= base_ff) && ((address_ff - base_ff) < HEAP_BYTES);
            state_in    = S_LAUNCH;
         end
         S_LAUNCH: begin
            if (func_ff == FUNC_FREE && !range_ok_ff) begin
               ok_in    = 1'b0;
               state_in = S_RESP;
            end else begin
               div_start = 1'b1;
               state_in  = S_DIV;
            end
         end
         S_DIV: begin
            if (div_stat.done) begin
               if (func_ff == FUNC_ALLOC) begin
                  need_in = div_q[NEED_W-1:0];
                  if (div_q[NEED_W-1:0] == '0) begin
                     ok_in    = 1'b0;
                     state_in = S_RESP;
                  end else begin
                     rd_en       = 1'b1;
                     rd_addr     = '0;
                     cur_word_in = '0;
                     carry_in    = '0;
                     state_in    = S_SCAN;
                  end
               end else begin
                  idx_blk_in  = div_qx[GB_W-1:0];
                  rd_en       = 1'b1;
                  rd_addr     = div_qx[GB_W-1:LANE_W];
                  cur_word_in = div_qx[GB_W-1:LANE_W];
                  state_in    = S_FREE;
               end
            end
         end
         S_SCAN: begin
            if (hit) begin
               // rewind to the word holding the run's first block
               start_blk_in = start_sw[GB_W-1:0];
               end_blk_in   = hit_blk;
               rd_en        = 1'b1;
               rd_addr      = start_sw[GB_W-1:LANE_W];
               cur_word_in  = start_sw[GB_W-1:LANE_W];
               state_in     = S_MARK;
            end else if (cur_word_ff == LAST_WORD) begin
               ok_in    = 1'b0;
               state_in = S_RESP;
            end else begin
               carry_in    = carry_next;
               rd_en       = 1'b1;
               rd_addr     = cur_word_ff + WA_W'(1);
               cur_word_in = cur_word_ff + WA_W'(1);
            end
         end
         S_MARK: begin
            wr_en   = 1'b1;
            wr_data = mark_wdata;
            if (cur_word_ff == end_word) begin
               ok_in    = 1'b1;
               state_in = S_RESP;
            end else begin
               rd_en       = 1'b1;
               rd_addr     = cur_word_ff + WA_W'(1);
               cur_word_in = cur_word_ff + WA_W'(1);
            end
         end
         S_FREE: begin
            wr_en   = 1'b1;
            wr_data = free_wdata;
            if (free_last) begin
               ok_in    = 1'b1;
               state_in = S_RESP;
            end else begin
               rd_en       = 1'b1;
               rd_addr     = cur_word_ff + WA_W'(1);
               cur_word_in = cur_word_ff + WA_W'(1);
            end
         end
         S_RESP: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_addr_in  = rsp_addr_ff;
      rsp_ok_in    = rsp_ok_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_ok_in    = ok_ff;
         rsp_addr_in  = (func_ff == FUNC_ALLOC && ok_ff) ? base_ff + ADDR_W'(prod_ff)
                                                         : '0;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cur_word_ff  <= '0;
         base_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_word_ff  <= cur_word_in;
         base_ff      <= base_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      func_ff      <= func_in;
      size_ff      <= size_in;
      address_ff   <= address_in;
      offset_ff    <= offset_in;
      range_ok_ff  <= range_ok_in;
      need_ff      <= need_in;
      carry_ff     <= carry_in;
      idx_blk_ff   <= idx_blk_in;
      start_blk_ff <= start_blk_in;
      end_blk_ff   <= end_blk_in;
      ok_ff        <= ok_in;
      prod_ff      <= prod_in;
      rsp_addr_ff  <= rsp_addr_in;
      rsp_ok_ff    <= rsp_ok_in;
   end

   assign req_stall          = (state_ff != S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_address = rsp_addr_ff;
   assign rsp_success        = rsp_ok_ff;

   // -----------------------------------------------------------------------
   // Assertions
   // -----------------------------------------------------------------------
   `BBA_ASSERT(a_no_rw_same_word, clock, reset, wr_en && rd_en, wr_addr != rd_addr, "read and write hit the same state word")
   `BBA_ASSERT(a_div_done_in_div, clock, reset, div_stat.done, state_ff == S_DIV, "divider finished outside the divide state")
   `BBA_ASSERT(a_div_busy_in_div, clock, reset, div_stat.busy, state_ff == S_DIV, "divider busy outside the divide state")
   `BBA_ASSERT(a_mark_in_run, clock, reset, state_ff == S_MARK, cur_word_ff >= start_word && cur_word_ff <= end_word, "marking outside the allocated run")
   `BBA_ASSERT_NEXT(a_rsp_loaded, clock, reset, rsp_load, rsp_valid && state_ff == S_IDLE, "finished item not presented")

endmodule

`default_nettype wire
